[hw/rtl/tta_pkg.sv]
// shared types, constants and helper functions for the tangent accumulator
package tta_pkg;

  // vertex store geometry
  localparam int MAX_VERTICES = 4096;
  localparam int VTX_AW       = $clog2(MAX_VERTICES);
  localparam int SUM_W        = 6 * 32;

  // request and result codes
  localparam logic REQ_CORNER = 1'b0;
  localparam logic REQ_READ   = 1'b1;
  localparam logic KIND_TRI   = 1'b0;
  localparam logic KIND_SUMS  = 1'b1;

  // multiplier operand slots: products for det and vectors, then squares
  localparam logic [4:0] MI_VEC_LAST = 5'd13;
  localparam logic [4:0] MI_SQ0      = 5'd14;

  typedef struct packed {
    logic               req_type;
    logic [11:0]        vertex_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic               degenerate;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
    logic signed [31:0] bitan_x;
    logic signed [31:0] bitan_y;
    logic signed [31:0] bitan_z;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic              in_take;
    logic              hold_wr;
    logic              hold_slot;
    logic              delta_ld;
    logic              mul_issue;
    logic [4:0]        mul_idx;
    logic              mul_take;
    logic [4:0]        take_idx;
    logic              sign_fix;
    logic              mag_ld;
    logic              grp;
    logic              shift_step;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              div_init;
    logic              div_step;
    logic              div_store;
    logic [1:0]        comp;
    logic              ram_rd;
    logic              rd_of_req;
    logic [1:0]        vsel;
    logic              acc_wr;
    logic              rd_capture;
    logic              clr_we;
    logic [VTX_AW-1:0] clr_addr;
    logic              out_ld;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic big;
  } sts_t;

  // saturating 32 bit subtract
  function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return d[31:0];
  endfunction

  // saturating 32 bit add
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return s[31:0];
  endfunction

  // vertex lies inside the sum store
  function automatic logic vtx_in_range(input logic [11:0] v);
    return 32'(v) < MAX_VERTICES;
  endfunction

endpackage

[hw/rtl/tta_ram.sv]
// generic single write, single read ram with registered read data
module tta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/tta_datapath.sv]
// datapath: corner store, shared multiplier, root and divide units, sum store
module tta_datapath
  import tta_pkg::*;
(
  input  logic      clk,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  output sts_t      sts,
  output out_item_t out_data
);

  in_item_t    cur_r;
  logic [31:0] hp_r  [2][3];
  logic [31:0] huv_r [2][2];
  logic [11:0] hv_r  [2];
  logic [31:0] dp1_r [3];
  logic [31:0] dp2_r [3];
  logic [31:0] du1_r, dv1_r, du2_r, dv2_r;
  logic [63:0] prod_r, first_r, det_r, sum_r;
  logic [63:0] vec_r [6];
  logic [63:0] m_r   [3];
  logic        neg_r [3];
  logic [63:0] sq_v_r, sq_q_r, sq_bit_r;
  logic [47:0] num_r, quo_r;
  logic [32:0] rem_r;
  logic        res_kind_r, res_degen_r;
  logic [31:0] res_t_r [3];
  logic [31:0] res_b_r [3];
  out_item_t   out_r;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic [2:0]         vdst;
  logic [63:0]        diff;
  logic [63:0]        sq_rb;
  logic [32:0]        rem_s;
  logic [31:0]        q32;
  logic [11:0]        sel_vtx;
  logic [11:0]        rd_vtx;
  logic               ram_we;
  logic [VTX_AW-1:0]  ram_waddr;
  logic [SUM_W-1:0]   ram_wdata;
  logic [SUM_W-1:0]   ram_rdata;
  logic [SUM_W-1:0]   acc_data;
  logic [31:0]        rd_word [6];

  // multiplier operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_idx)
      5'd0:    begin op_a = {du1_r[31], du1_r};       op_b = {dv2_r[31], dv2_r}; end
      5'd1:    begin op_a = {dv1_r[31], dv1_r};       op_b = {du2_r[31], du2_r}; end
      5'd2:    begin op_a = {dv2_r[31], dv2_r};       op_b = {dp1_r[0][31], dp1_r[0]}; end
      5'd3:    begin op_a = {dv1_r[31], dv1_r};       op_b = {dp2_r[0][31], dp2_r[0]}; end
      5'd4:    begin op_a = {dv2_r[31], dv2_r};       op_b = {dp1_r[1][31], dp1_r[1]}; end
      5'd5:    begin op_a = {dv1_r[31], dv1_r};       op_b = {dp2_r[1][31], dp2_r[1]}; end
      5'd6:    begin op_a = {dv2_r[31], dv2_r};       op_b = {dp1_r[2][31], dp1_r[2]}; end
      5'd7:    begin op_a = {dv1_r[31], dv1_r};       op_b = {dp2_r[2][31], dp2_r[2]}; end
      5'd8:    begin op_a = {du1_r[31], du1_r};       op_b = {dp2_r[0][31], dp2_r[0]}; end
      5'd9:    begin op_a = {du2_r[31], du2_r};       op_b = {dp1_r[0][31], dp1_r[0]}; end
      5'd10:   begin op_a = {du1_r[31], du1_r};       op_b = {dp2_r[1][31], dp2_r[1]}; end
      5'd11:   begin op_a = {du2_r[31], du2_r};       op_b = {dp1_r[1][31], dp1_r[1]}; end
      5'd12:   begin op_a = {du1_r[31], du1_r};       op_b = {dp2_r[2][31], dp2_r[2]}; end
      5'd13:   begin op_a = {du2_r[31], du2_r};       op_b = {dp1_r[2][31], dp1_r[2]}; end
      5'd14:   begin op_a = {2'b00, m_r[0][30:0]};    op_b = {2'b00, m_r[0][30:0]}; end
      5'd15:   begin op_a = {2'b00, m_r[1][30:0]};    op_b = {2'b00, m_r[1][30:0]}; end
      5'd16:   begin op_a = {2'b00, m_r[2][30:0]};    op_b = {2'b00, m_r[2][30:0]}; end
      default: begin op_a = '0;                       op_b = '0; end
    endcase
  end

  assign prod  = op_a * op_b;
  assign vdst  = 3'(cmd.take_idx[4:1] - 4'd1);
  assign diff  = first_r - prod_r;
  assign sq_rb = sq_q_r + sq_bit_r;
  assign rem_s = {rem_r[31:0], num_r[47]};
  assign q32   = quo_r[31:0];

  // vertex selection for the sum store
  always_comb begin
    case (cmd.vsel)
      2'd0:    sel_vtx = hv_r[0];
      2'd1:    sel_vtx = hv_r[1];
      default: sel_vtx = cur_r.vertex_index;
    endcase
  end
  assign rd_vtx = cmd.rd_of_req ? cur_r.vertex_index : sel_vtx;

  // unpack stored sums and form the saturated new sums
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rd_word[i] = ram_rdata[SUM_W-1-32*i -: 32];
    end
    acc_data = {sat_add32(rd_word[0], res_t_r[0]), sat_add32(rd_word[1], res_t_r[1]),
                sat_add32(rd_word[2], res_t_r[2]), sat_add32(rd_word[3], res_b_r[0]),
                sat_add32(rd_word[4], res_b_r[1]), sat_add32(rd_word[5], res_b_r[2])};
  end

  // store write port: clearing pass or accumulation
  always_comb begin
    if (cmd.clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = cmd.clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.acc_wr && vtx_in_range(sel_vtx);
      ram_waddr = VTX_AW'(sel_vtx);
      ram_wdata = acc_data;
    end
  end

  tta_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_VERTICES)
  ) u_sums (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (cmd.ram_rd),
    .rd_addr(VTX_AW'(rd_vtx)),
    .rd_data(ram_rdata)
  );

  // input capture and held corners
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      cur_r <= in_data;
    end
    if (cmd.hold_wr) begin
      hp_r[cmd.hold_slot][0]  <= in_data.pos_x;
      hp_r[cmd.hold_slot][1]  <= in_data.pos_y;
      hp_r[cmd.hold_slot][2]  <= in_data.pos_z;
      huv_r[cmd.hold_slot][0] <= in_data.tex_u;
      huv_r[cmd.hold_slot][1] <= in_data.tex_v;
      hv_r[cmd.hold_slot]     <= in_data.vertex_index;
    end
  end

  // edge and uv deltas
  always_ff @(posedge clk) begin
    if (cmd.delta_ld) begin
      dp1_r[0] <= sat_sub32(hp_r[1][0], hp_r[0][0]);
      dp1_r[1] <= sat_sub32(hp_r[1][1], hp_r[0][1]);
      dp1_r[2] <= sat_sub32(hp_r[1][2], hp_r[0][2]);
      dp2_r[0] <= sat_sub32(cur_r.pos_x, hp_r[0][0]);
      dp2_r[1] <= sat_sub32(cur_r.pos_y, hp_r[0][1]);
      dp2_r[2] <= sat_sub32(cur_r.pos_z, hp_r[0][2]);
      du1_r    <= sat_sub32(huv_r[1][0], huv_r[0][0]);
      dv1_r    <= sat_sub32(huv_r[1][1], huv_r[0][1]);
      du2_r    <= sat_sub32(cur_r.tex_u, huv_r[0][0]);
      dv2_r    <= sat_sub32(cur_r.tex_v, huv_r[0][1]);
    end
  end

  // product register and pairing of products into det and vector terms
  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      prod_r <= prod[63:0];
    end
    if (cmd.mul_take) begin
      if (cmd.take_idx >= MI_SQ0) begin
        sum_r <= (cmd.take_idx == MI_SQ0) ? prod_r : sum_r + prod_r;
      end else if (!cmd.take_idx[0]) begin
        first_r <= prod_r;
      end else if (cmd.take_idx[4:1] == 4'd0) begin
        det_r <= diff;
      end else begin
        vec_r[vdst] <= diff;
      end
    end
    if (cmd.sign_fix && det_r[63]) begin
      for (int i = 0; i < 6; i++) begin
        vec_r[i] <= 64'd0 - vec_r[i];
      end
    end
  end

  // magnitudes and normalising right shift
  always_ff @(posedge clk) begin
    if (cmd.mag_ld) begin
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= vec_r[cmd.grp ? k + 3 : k][63];
        m_r[k]   <= vec_r[cmd.grp ? k + 3 : k][63] ? 64'd0 - vec_r[cmd.grp ? k + 3 : k]
                                                   : vec_r[cmd.grp ? k + 3 : k];
      end
    end else if (cmd.shift_step) begin
      for (int k = 0; k < 3; k++) begin
        m_r[k] <= m_r[k] >> 1;
      end
    end
  end

  // bitwise square root, one result bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_v_r   <= sum_r;
      sq_q_r   <= '0;
      sq_bit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (sq_v_r >= sq_rb) begin
        sq_v_r <= sq_v_r - sq_rb;
        sq_q_r <= (sq_q_r >> 1) + sq_bit_r;
      end else begin
        sq_q_r <= sq_q_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r <= {1'b0, m_r[cmd.comp][30:0], 16'h0000} + 48'(sq_q_r[31:1]);
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      if (rem_s >= {1'b0, sq_q_r[31:0]}) begin
        rem_r <= rem_s - {1'b0, sq_q_r[31:0]};
        quo_r <= {quo_r[46:0], 1'b1};
      end else begin
        rem_r <= rem_s;
        quo_r <= {quo_r[46:0], 1'b0};
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.delta_ld) begin
      res_kind_r <= KIND_TRI;
      for (int k = 0; k < 3; k++) begin
        res_t_r[k] <= '0;
        res_b_r[k] <= '0;
      end
    end
    if (cmd.sign_fix) begin
      res_degen_r <= (det_r == 64'd0);
    end
    if (cmd.div_store) begin
      if (cmd.grp) begin
        res_b_r[cmd.comp] <= neg_r[cmd.comp] ? 32'd0 - q32 : q32;
      end else begin
        res_t_r[cmd.comp] <= neg_r[cmd.comp] ? 32'd0 - q32 : q32;
      end
    end
    if (cmd.rd_capture) begin
      res_kind_r  <= KIND_SUMS;
      res_degen_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        res_t_r[k] <= vtx_in_range(cur_r.vertex_index) ? rd_word[k] : 32'd0;
        res_b_r[k] <= vtx_in_range(cur_r.vertex_index) ? rd_word[k + 3] : 32'd0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_r <= '{result_kind: res_kind_r, degenerate: res_degen_r,
                 tan_x: res_t_r[0], tan_y: res_t_r[1], tan_z: res_t_r[2],
                 bitan_x: res_b_r[0], bitan_y: res_b_r[1], bitan_z: res_b_r[2]};
    end
  end

  assign out_data     = out_r;
  assign sts.det_zero = (det_r == 64'd0);
  assign sts.vec_zero = (m_r[0] == 64'd0) && (m_r[1] == 64'd0) && (m_r[2] == 64'd0);
  assign sts.big      = (|m_r[0][63:31]) || (|m_r[1][63:31]) || (|m_r[2][63:31]);

endmodule

[hw/rtl/tta_ctrl.sv]
// controller: sequences the clearing pass, corner collection, reads, vector math, accumulation and output
module tta_ctrl
  import tta_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_req_type,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [14:0] {
    ST_CLEAR = 15'b000000000000001,
    ST_IDLE  = 15'b000000000000010,
    ST_RD    = 15'b000000000000100,
    ST_RDCAP = 15'b000000000001000,
    ST_DELTA = 15'b000000000010000,
    ST_MUL   = 15'b000000000100000,
    ST_SIGN  = 15'b000000001000000,
    ST_MAG   = 15'b000000010000000,
    ST_SHIFT = 15'b000000100000000,
    ST_SQ    = 15'b000001000000000,
    ST_SQRT  = 15'b000010000000000,
    ST_DIV   = 15'b000100000000000,
    ST_ACCRD = 15'b001000000000000,
    ST_ACCWR = 15'b010000000000000,
    ST_OUT   = 15'b100000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [VTX_AW-1:0] clr_r, clr_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              g_r, g_nxt;
  logic [1:0]        j_r, j_nxt;
  logic [1:0]        corners_r, corners_nxt;
  logic              enable_r, enable_nxt;
  logic              out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    g_nxt       = g_r;
    j_nxt       = j_r;
    corners_nxt = corners_r;
    enable_nxt  = cfg_wr_en ? cfg_wr_data : enable_r;
    cmd         = '0;
    cmd.grp     = g_r;
    cmd.comp    = k_r;
    cmd.vsel    = j_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we   = 1'b1;
        cmd.clr_addr = clr_r;
        clr_nxt      = clr_r + VTX_AW'(1);
        if (clr_r == VTX_AW'(MAX_VERTICES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          if (in_req_type == REQ_READ) begin
            state_nxt = ST_RD;
          end else if (enable_r) begin
            if (corners_r != 2'd2) begin
              cmd.hold_wr   = 1'b1;
              cmd.hold_slot = corners_r[0];
              corners_nxt   = corners_r + 2'd1;
            end else begin
              corners_nxt = 2'd0;
              state_nxt   = ST_DELTA;
            end
          end
        end
      end
      ST_RD: begin
        cmd.ram_rd    = 1'b1;
        cmd.rd_of_req = 1'b1;
        state_nxt     = ST_RDCAP;
      end
      ST_RDCAP: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_DELTA: begin
        cmd.delta_ld = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      // fourteen products through the shared multiplier, each taken in the cycle after its issue
      ST_MUL: begin
        cmd.mul_issue = (cnt_r[4:0] <= MI_VEC_LAST);
        cmd.mul_idx   = cnt_r[4:0];
        cmd.mul_take  = (cnt_r != 6'd0);
        cmd.take_idx  = cnt_r[4:0] - 5'd1;
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r[4:0] == MI_VEC_LAST + 5'd1) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cmd.sign_fix = 1'b1;
        g_nxt        = 1'b0;
        j_nxt        = 2'd0;
        state_nxt    = sts.det_zero ? ST_ACCRD : ST_MAG;
      end
      ST_MAG: begin
        cmd.mag_ld = 1'b1;
        state_nxt  = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts.vec_zero) begin
          g_nxt     = 1'b1;
          j_nxt     = 2'd0;
          state_nxt = g_r ? ST_ACCRD : ST_MAG;
        end else if (sts.big) begin
          cmd.shift_step = 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end
      // sum of squares
      ST_SQ: begin
        cmd.mul_issue = (cnt_r < 6'd3);
        cmd.mul_idx   = MI_SQ0 + cnt_r[4:0];
        cmd.mul_take  = (cnt_r != 6'd0);
        cmd.take_idx  = MI_SQ0 + cnt_r[4:0] - 5'd1;
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == 6'd3) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_init = (cnt_r == 6'd0);
        cmd.sqrt_step = (cnt_r != 6'd0);
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          cnt_nxt   = '0;
          k_nxt     = 2'd0;
          state_nxt = ST_DIV;
        end
      end
      // one component: load, 48 quotient bits, store
      ST_DIV: begin
        cmd.div_init  = (cnt_r == 6'd0);
        cmd.div_step  = (cnt_r != 6'd0) && (cnt_r != 6'd49);
        cmd.div_store = (cnt_r == 6'd49);
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == 6'd49) begin
          cnt_nxt = '0;
          if (k_r == 2'd2) begin
            g_nxt     = 1'b1;
            j_nxt     = 2'd0;
            state_nxt = g_r ? ST_ACCRD : ST_MAG;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      ST_ACCRD: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = ST_ACCWR;
      end
      ST_ACCWR: begin
        cmd.acc_wr = 1'b1;
        j_nxt      = j_r + 2'd1;
        state_nxt  = (j_r == 2'd2) ? ST_OUT : ST_ACCRD;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_ld | (out_valid_r & out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      g_r         <= 1'b0;
      j_r         <= '0;
      corners_r   <= '0;
      enable_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      g_r         <= g_nxt;
      j_r         <= j_nxt;
      corners_r   <= corners_nxt;
      enable_r    <= enable_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/triangle_tangent_accumulator_core.sv]
// top level of the per-triangle tangent and bitangent accumulator
// a first or second corner is stored as it is taken; a read request passes the read,
// capture and output states; the time for a third corner is set by one shared multiplier,
// a bitwise root per vector and a restoring divider per component
// one transaction is in work at a time; the next is taken while a result waits
// reset is synchronous; afterwards a clearing pass zeroes all 4096 sum entries, input stalled
module triangle_tangent_accumulator_core
  import tta_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_data.req_type),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .sts        (sts)
  );

  // arithmetic and storage
  tta_datapath u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .in_data (in_data),
    .sts     (sts),
    .out_data(out_data)
  );

  // clearing pass holds input off right after reset
  assert property (@(posedge clk) disable iff (!rst_n) !$past(rst_n) |-> in_stall)
    else $error("input taken during clearing pass");

  // a sums transaction never reports a degenerate triangle
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_data.result_kind == KIND_SUMS |-> !out_data.degenerate)
    else $error("degenerate flag on read result");

  // a degenerate triangle gives zero vectors
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_data.degenerate |->
                   out_data.tan_x == 0 && out_data.tan_y == 0 && out_data.tan_z == 0 &&
                   out_data.bitan_x == 0 && out_data.bitan_y == 0 && out_data.bitan_z == 0)
    else $error("nonzero vectors on degenerate triangle");

  // an accepted input is never followed by a new result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
                   in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared without processing time");

endmodule
